>>> rtl/mwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared constants, register codes and job types of the median window filter.
// ----------------------------------------------------------------------------
package mwf_pkg;

  localparam int CH_W           = 8;
  localparam int NUM_CH         = 3;
  localparam int PIX_W          = NUM_CH * CH_W;
  localparam int SIDE_W         = 3;
  localparam int LEN_REG_W      = 12;
  localparam int COL_OUT_W      = 11;
  localparam int ROW_W          = 12;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 4;

  localparam int DEF_MAX_WINDOW = 7;
  localparam int DEF_MAX_LINE   = 2048;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [SIDE_W-1:0]    RST_WIN_W    = 3'd3;
  localparam logic [SIDE_W-1:0]    RST_WIN_H    = 3'd3;
  localparam logic [LEN_REG_W-1:0] RST_LINE_LEN = 12'd640;
  localparam logic                 RST_COLOR    = 1'b0;

  typedef enum logic [1:0] {
    REG_WIN_W    = 2'd0,
    REG_WIN_H    = 2'd1,
    REG_LINE_LEN = 2'd2,
    REG_COLOR    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [SIDE_W-1:0]    win_w;
    logic [SIDE_W-1:0]    win_h;
    logic [LEN_REG_W-1:0] line_len;
    logic                 color;
  } cfg_t;

  // Everything about one window except its pixels.
  typedef struct packed {
    logic [SIDE_W-1:0]    side_w;
    logic [SIDE_W-1:0]    side_h;
    logic                 color;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
  } job_meta_t;

  // Odd window side, capped at the largest odd value the window store holds.
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] k, input int cap);
    logic [SIDE_W-1:0] s;
    s = {k[SIDE_W-1:1], 1'b1};
    if (int'(s) > cap) begin
      s = SIDE_W'(cap);
    end
    return s;
  endfunction

endpackage

>>> rtl/mwf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_pix_if / mwf_med_if
// Valid/ready channels for input pixels and for median results.
// ----------------------------------------------------------------------------
interface mwf_pix_if import mwf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] chan_blue;
  logic [CH_W-1:0] chan_green;
  logic [CH_W-1:0] chan_red;
  logic            frame_start;

  modport source (output valid, chan_blue, chan_green, chan_red, frame_start, input ready);
  modport sink   (input valid, chan_blue, chan_green, chan_red, frame_start, output ready);
endinterface

interface mwf_med_if import mwf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CH_W-1:0]      med_blue;
  logic [CH_W-1:0]      med_green;
  logic [CH_W-1:0]      med_red;
  logic [COL_OUT_W-1:0] out_col;
  logic [ROW_W-1:0]     out_row;

  modport source (output valid, med_blue, med_green, med_red, out_col, out_row, input ready);
  modport sink   (input valid, med_blue, med_green, med_red, out_col, out_row, output ready);
endinterface

>>> rtl/mwf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_front
// Raster counters, line stores and the sliding window; emits window jobs.
// ----------------------------------------------------------------------------
module mwf_front import mwf_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int MAX_LINE   = DEF_MAX_LINE
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  mwf_pix_if.sink                                 pix_i,
  input  cfg_t                                    cfg_i,
  input  logic                                    room_i,
  output logic                                    busy_o,
  output logic                                    push_o,
  output logic [MAX_WINDOW*MAX_WINDOW*PIX_W-1:0]  cells_o,
  output job_meta_t                               meta_o
);

  localparam int NCELL   = MAX_WINDOW * MAX_WINDOW;
  localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int COL_W   = $clog2(MAX_LINE);
  localparam int LEN_W   = $clog2(MAX_LINE + 1);
  localparam int HELD_W  = $clog2(MAX_WINDOW + 1);
  localparam int ODD_CAP = (MAX_WINDOW - 1) | 1;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [HELD_W-1:0] held_inc(input logic [HELD_W-1:0] h);
    return (h < HELD_W'(MAX_WINDOW)) ? h + HELD_W'(1) : h;
  endfunction

  // Slot that holds the row d rows above the row in slot s.
  function automatic logic [SLOT_W-1:0] age_slot(input logic [SLOT_W-1:0] s, input int d);
    int t;
    t = int'(s) - d;
    if (t < 0) begin
      t = t + MAX_WINDOW;
    end
    return SLOT_W'(t);
  endfunction

  logic [COL_W-1:0]  col_q, col_d, col_c;
  logic [ROW_W-1:0]  row_q, row_d, row_c;
  logic [SLOT_W-1:0] slot_q, slot_d, slot_c;
  logic [HELD_W-1:0] held_q, held_d, held_c;

  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  col_inc;
  int                len_int;
  logic [SIDE_W-1:0] side_w, side_h;
  logic              acc;
  logic              produce;
  logic [PIX_W-1:0]  pix;

  logic                  s1_valid_q;
  logic                  s1_prod_q;
  logic [PIX_W-1:0]      s1_pix_q;
  logic [SLOT_W-1:0]     s1_slot_q;
  job_meta_t             s1_meta_q;
  job_meta_t             meta_c;

  logic [PIX_W-1:0]       rd_q  [MAX_WINDOW];
  logic [PIX_W-1:0]       stack [MAX_WINDOW];
  logic [NCELL*PIX_W-1:0] win_q, win_d;

  assign pix_i.ready = room_i;
  assign acc         = pix_i.valid & room_i;
  assign pix         = {pix_i.chan_red, pix_i.chan_green, pix_i.chan_blue};
  assign side_w      = eff_side(cfg_i.win_w, ODD_CAP);
  assign side_h      = eff_side(cfg_i.win_h, ODD_CAP);

  always_comb begin
    len_int = int'(cfg_i.line_len);
    if (len_int == 0) begin
      len_int = 1;
    end
    if (len_int > MAX_LINE) begin
      len_int = MAX_LINE;
    end
    eff_len = LEN_W'(len_int);
  end

  // Position of the pixel being taken, then the position after it.
  always_comb begin
    col_c  = col_q;
    row_c  = row_q;
    slot_c = slot_q;
    held_c = held_q;
    if (pix_i.frame_start) begin
      col_c  = '0;
      row_c  = '0;
      slot_c = '0;
      held_c = HELD_W'(1);
    end else if (LEN_W'(col_q) >= eff_len) begin
      col_c  = '0;
      row_c  = row_q + ROW_W'(1);
      slot_c = slot_inc(slot_q);
      held_c = held_inc(held_q);
    end

    col_inc = LEN_W'(col_c) + LEN_W'(1);
    produce = (int'(held_c) >= int'(side_h)) && (col_inc >= LEN_W'(side_w));

    meta_c.side_w = side_w;
    meta_c.side_h = side_h;
    meta_c.color  = cfg_i.color;
    meta_c.col    = COL_OUT_W'(col_inc - LEN_W'(side_w));
    meta_c.row    = row_c - ROW_W'(side_h) + ROW_W'(1);

    if (col_inc >= eff_len) begin
      col_d  = '0;
      row_d  = row_c + ROW_W'(1);
      slot_d = slot_inc(slot_c);
      held_d = held_inc(held_c);
    end else begin
      col_d  = COL_W'(col_inc);
      row_d  = row_c;
      slot_d = slot_c;
      held_d = held_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      slot_q     <= '0;
      held_q     <= HELD_W'(1);
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc;
      if (acc) begin
        col_q  <= col_d;
        row_q  <= row_d;
        slot_q <= slot_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_prod_q <= produce;
      s1_pix_q  <= pix;
      s1_slot_q <= slot_c;
      s1_meta_q <= meta_c;
    end
    if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  // One row store per slot; all are read at the current column.
  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_line
    logic [PIX_W-1:0] mem [MAX_LINE];

    always_ff @(posedge clk_i) begin
      if (acc) begin
        if (slot_c == SLOT_W'(g)) begin
          mem[col_c] <= pix;
        end
        rd_q[g] <= mem[col_c];
      end
    end
  end

  // The new column, newest row first, enters the window at column age zero.
  always_comb begin
    stack[0] = s1_pix_q;
    for (int d = 1; d < MAX_WINDOW; d++) begin
      stack[d] = rd_q[age_slot(s1_slot_q, d)];
    end
    for (int a = 0; a < MAX_WINDOW; a++) begin
      for (int d = 0; d < MAX_WINDOW; d++) begin
        if (a == 0) begin
          win_d[(a*MAX_WINDOW + d)*PIX_W +: PIX_W] = stack[d];
        end else begin
          win_d[(a*MAX_WINDOW + d)*PIX_W +: PIX_W] =
            win_q[((a-1)*MAX_WINDOW + d)*PIX_W +: PIX_W];
        end
      end
    end
  end

  assign busy_o  = s1_valid_q;
  assign push_o  = s1_valid_q & s1_prod_q;
  assign cells_o = win_d;
  assign meta_o  = s1_meta_q;

endmodule

>>> rtl/mwf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_queue
// Short job queue between the window front and the median pipeline.
// ----------------------------------------------------------------------------
module mwf_queue import mwf_pkg::*; #(
  parameter int CELLS_W = DEF_MAX_WINDOW * DEF_MAX_WINDOW * PIX_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [CELLS_W-1:0] cells_i,
  input  job_meta_t          meta_i,
  input  logic               pend_i,
  output logic               room_o,
  input  logic               pop_i,
  output logic               valid_o,
  output logic [CELLS_W-1:0] cells_o,
  output job_meta_t          meta_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CELLS_W-1:0] cells_q [QUEUE_DEPTH];
  job_meta_t          meta_q  [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Room for a job still in the front plus one more pixel taken now.
  assign room_o  = (int'(cnt_q) + int'(pend_i) + 1) <= QUEUE_DEPTH;
  assign valid_o = (cnt_q != '0);
  assign cells_o = cells_q[rd_ptr_q];
  assign meta_o  = meta_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cells_q[wr_ptr_q] <= cells_i;
      meta_q[wr_ptr_q]  <= meta_i;
    end
  end

endmodule

>>> rtl/mwf_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_median
// Bit-by-bit median pipeline: one stage resolves one bit of each channel.
// ----------------------------------------------------------------------------
module mwf_median import mwf_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic [MAX_WINDOW*MAX_WINDOW*PIX_W-1:0] cells_i,
  input  job_meta_t                              meta_i,
  output logic                                   pop_o,
  mwf_med_if.source                              med_o
);

  localparam int NCELL = MAX_WINDOW * MAX_WINDOW;
  localparam int KW    = $clog2(NCELL + 1);
  localparam int NST   = CH_W;

  logic                   v_q     [NST+1];
  job_meta_t              meta_q  [NST+1];
  logic [NCELL*PIX_W-1:0] cells_q [NST];
  logic [NCELL-1:0]       mask_q  [NUM_CH][NST+1];
  logic [KW-1:0]          k_q     [NUM_CH][NST+1];
  logic [CH_W-1:0]        med_q   [NUM_CH][NST+1];

  logic             en;
  logic [NCELL-1:0] mask_init;
  logic [5:0]       prod;

  assign en    = !v_q[NST] || med_o.ready;
  assign pop_o = en && valid_i;

  // Cells of the window proper, and the rank of the median among them.
  always_comb begin
    for (int a = 0; a < MAX_WINDOW; a++) begin
      for (int d = 0; d < MAX_WINDOW; d++) begin
        mask_init[a*MAX_WINDOW + d] = (a < int'(meta_i.side_w)) && (d < int'(meta_i.side_h));
      end
    end
    prod = 6'(meta_i.side_w) * 6'(meta_i.side_h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NST; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= valid_i;
      for (int s = 1; s <= NST; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0]  <= meta_i;
      cells_q[0] <= cells_i;
      for (int s = 1; s <= NST; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
      for (int s = 1; s < NST; s++) begin
        cells_q[s] <= cells_q[s-1];
      end
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_load
    always_ff @(posedge clk_i) begin
      if (en) begin
        mask_q[c][0] <= mask_init;
        k_q[c][0]    <= KW'(prod >> 1);
        med_q[c][0]  <= '0;
      end
    end
  end

  // Stage s fixes bit CH_W-s: if the candidates with a zero there number no
  // more than the rank, the median has a one and the rank skips past the zeros.
  for (genvar s = 1; s <= NST; s++) begin : g_stage
    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
      logic [NCELL-1:0] ones;
      logic [NCELL-1:0] zeros;
      logic [KW-1:0]    cnt;
      logic             bit_one;

      always_comb begin
        for (int i = 0; i < NCELL; i++) begin
          ones[i] = cells_q[s-1][i*PIX_W + c*CH_W + (CH_W - s)];
        end
        zeros = mask_q[c][s-1] & ~ones;
        cnt   = '0;
        for (int i = 0; i < NCELL; i++) begin
          cnt = cnt + KW'(zeros[i]);
        end
        bit_one = (k_q[c][s-1] >= cnt);
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          if (bit_one) begin
            mask_q[c][s] <= mask_q[c][s-1] & ones;
            k_q[c][s]    <= k_q[c][s-1] - cnt;
          end else begin
            mask_q[c][s] <= zeros;
            k_q[c][s]    <= k_q[c][s-1];
          end
          med_q[c][s] <= {med_q[c][s-1][CH_W-2:0], bit_one};
        end
      end
    end
  end

  assign med_o.valid     = v_q[NST];
  assign med_o.med_blue  = med_q[0][NST];
  assign med_o.med_green = meta_q[NST].color ? med_q[1][NST] : '0;
  assign med_o.med_red   = meta_q[NST].color ? med_q[2][NST] : '0;
  assign med_o.out_col   = meta_q[NST].col;
  assign med_o.out_row   = meta_q[NST].row;

endmodule

>>> rtl/median_window_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_window_filter
// Per-channel median over an odd 2-D window of a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on pix_i in row order, one transfer per pixel; frame_start on
// a pixel restarts the row and column counters. When a pixel completes a full
// window as its bottom-right corner, one result leaves on med_o with the
// medians and the window's top-left column and row; other pixels give none.
// The block takes one pixel per cycle while pix_i.ready is high. A result
// passes the line store read stage, the job queue and the median pipeline,
// which fixes one bit per stage. Registers are to be written over the APB
// port by the user only while the block is idle; the block does not enforce
// it. Reset clears counters, the queue and the pipeline; the line stores
// are not cleared. When med_o stalls, the median pipeline holds, the
// four-entry queue fills and pix_i.ready drops until space returns.
// ----------------------------------------------------------------------------
module median_window_filter import mwf_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int MAX_LINE   = DEF_MAX_LINE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mwf_pix_if.sink           pix_i,
  mwf_med_if.source         med_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CELLS_W = MAX_WINDOW * MAX_WINDOW * PIX_W;

  cfg_t               cfg_q;
  reg_idx_e           reg_idx;
  logic               wr_en;
  logic               room, busy, push, pop, q_valid;
  logic [CELLS_W-1:0] f_cells, q_cells;
  job_meta_t          f_meta, q_meta;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_w    <= RST_WIN_W;
      cfg_q.win_h    <= RST_WIN_H;
      cfg_q.line_len <= RST_LINE_LEN;
      cfg_q.color    <= RST_COLOR;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIN_W:    cfg_q.win_w    <= pwdata[SIDE_W-1:0];
        REG_WIN_H:    cfg_q.win_h    <= pwdata[SIDE_W-1:0];
        REG_LINE_LEN: cfg_q.line_len <= pwdata[LEN_REG_W-1:0];
        REG_COLOR:    cfg_q.color    <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIN_W:    prdata = DATA_W'(cfg_q.win_w);
      REG_WIN_H:    prdata = DATA_W'(cfg_q.win_h);
      REG_LINE_LEN: prdata = DATA_W'(cfg_q.line_len);
      REG_COLOR:    prdata = DATA_W'(cfg_q.color);
      default:      prdata = '0;
    endcase
  end

  mwf_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_LINE   (MAX_LINE)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_i),
    .cfg_i   (cfg_q),
    .room_i  (room),
    .busy_o  (busy),
    .push_o  (push),
    .cells_o (f_cells),
    .meta_o  (f_meta)
  );

  mwf_queue #(
    .CELLS_W (CELLS_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cells_i (f_cells),
    .meta_i  (f_meta),
    .pend_i  (busy),
    .room_o  (room),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cells_o (q_cells),
    .meta_o  (q_meta)
  );

  mwf_median #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cells_i (q_cells),
    .meta_i  (q_meta),
    .pop_o   (pop),
    .med_o   (med_o)
  );

endmodule

>>> rtl/mwf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_checker
// Port-level checks of the median window filter, bound to its top level.
// ----------------------------------------------------------------------------
module mwf_checker import mwf_pkg::*; (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic [NUM_CH*CH_W+COL_OUT_W+ROW_W-1:0] out_data_i,
  input logic                                 psel_i,
  input logic                                 penable_i,
  input logic                                 pwrite_i,
  input logic [ADDR_W-1:0]                    paddr_i,
  input logic [DATA_W-1:0]                    pwdata_i,
  input logic [DATA_W-1:0]                    prdata_i
);

  logic wr;
  assign wr = psel_i && penable_i && pwrite_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result pending right after reset");

  a_width_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && (paddr_i[3:2] == REG_WIN_W) |=>
      (paddr_i[3:2] != REG_WIN_W) || (prdata_i[2:0] == $past(pwdata_i[2:0])))
    else $error("window width does not read back");

  a_len_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && (paddr_i[3:2] == REG_LINE_LEN) |=>
      (paddr_i[3:2] != REG_LINE_LEN) || (prdata_i[11:0] == $past(pwdata_i[11:0])))
    else $error("line length does not read back");

endmodule

bind median_window_filter mwf_checker u_mwf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (med_o.valid),
  .out_ready_i (med_o.ready),
  .out_data_i  ({med_o.med_blue, med_o.med_green, med_o.med_red,
                 med_o.out_col, med_o.out_row}),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);
